// ===== hdl/cl3_geometric_product_unit_assert.svh =====
// Assertion macros for the Cl(3,0) geometric product unit.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef CL3_GEOMETRIC_PRODUCT_UNIT_ASSERT_SVH
`define CL3_GEOMETRIC_PRODUCT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define CL3_GPU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cl3 geometric product unit: same-cycle check failed");

// Next-cycle implication.
`define CL3_GPU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cl3 geometric product unit: next-cycle check failed");

`else

`define CL3_GPU_ASSERT_IMP(lbl, ante, cons)
`define CL3_GPU_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/cl3_gp_pkg.sv =====
package cl3_gp_pkg;

    localparam int FRAC_BITS = 8;
    localparam int COMP_W    = 16;
    localparam int NUM_BLADE = 8;
    localparam int LANES     = 4;
    localparam int PROD_W    = 2 * COMP_W;
    // eight products of up to 2**30 in magnitude, plus sign
    localparam int SUM_W     = PROD_W + 3;

    typedef struct packed {
        logic [63:0] left_low;
        logic [63:0] left_high;
        logic [63:0] right_low;
        logic [63:0] right_high;
    } t_gp_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] prod_scalar;
        logic signed [COMP_W-1:0] prod_e1;
        logic signed [COMP_W-1:0] prod_e2;
        logic signed [COMP_W-1:0] prod_e3;
        logic signed [COMP_W-1:0] prod_e12;
        logic signed [COMP_W-1:0] prod_e23;
        logic signed [COMP_W-1:0] prod_e13;
        logic signed [COMP_W-1:0] prod_e123;
    } t_gp_out;

    // blade index: 0 s, 1 e1, 2 e2, 3 e3, 4 e12, 5 e23, 6 e13, 7 e123
    typedef struct packed {
        logic [2:0] left;
        logic [2:0] right;
        logic       neg;
    } t_gp_term;

    localparam t_gp_term GP_TABLE [NUM_BLADE][NUM_BLADE] = '{
        '{'{3'd0, 3'd0, 1'b0}, '{3'd1, 3'd1, 1'b0}, '{3'd2, 3'd2, 1'b0}, '{3'd3, 3'd3, 1'b0},
          '{3'd4, 3'd4, 1'b1}, '{3'd5, 3'd5, 1'b1}, '{3'd6, 3'd6, 1'b1}, '{3'd7, 3'd7, 1'b1}},
        '{'{3'd0, 3'd1, 1'b0}, '{3'd1, 3'd0, 1'b0}, '{3'd2, 3'd4, 1'b1}, '{3'd4, 3'd2, 1'b0},
          '{3'd3, 3'd6, 1'b1}, '{3'd6, 3'd3, 1'b0}, '{3'd5, 3'd7, 1'b1}, '{3'd7, 3'd5, 1'b1}},
        '{'{3'd0, 3'd2, 1'b0}, '{3'd2, 3'd0, 1'b0}, '{3'd1, 3'd4, 1'b0}, '{3'd4, 3'd1, 1'b1},
          '{3'd3, 3'd5, 1'b1}, '{3'd5, 3'd3, 1'b0}, '{3'd6, 3'd7, 1'b0}, '{3'd7, 3'd6, 1'b0}},
        '{'{3'd0, 3'd3, 1'b0}, '{3'd3, 3'd0, 1'b0}, '{3'd1, 3'd6, 1'b0}, '{3'd6, 3'd1, 1'b1},
          '{3'd2, 3'd5, 1'b0}, '{3'd5, 3'd2, 1'b1}, '{3'd4, 3'd7, 1'b1}, '{3'd7, 3'd4, 1'b1}},
        '{'{3'd0, 3'd4, 1'b0}, '{3'd4, 3'd0, 1'b0}, '{3'd1, 3'd2, 1'b0}, '{3'd2, 3'd1, 1'b1},
          '{3'd3, 3'd7, 1'b0}, '{3'd7, 3'd3, 1'b0}, '{3'd5, 3'd6, 1'b0}, '{3'd6, 3'd5, 1'b1}},
        '{'{3'd0, 3'd5, 1'b0}, '{3'd5, 3'd0, 1'b0}, '{3'd2, 3'd3, 1'b0}, '{3'd3, 3'd2, 1'b1},
          '{3'd1, 3'd7, 1'b0}, '{3'd7, 3'd1, 1'b0}, '{3'd6, 3'd4, 1'b0}, '{3'd4, 3'd6, 1'b1}},
        '{'{3'd0, 3'd6, 1'b0}, '{3'd6, 3'd0, 1'b0}, '{3'd1, 3'd3, 1'b0}, '{3'd3, 3'd1, 1'b1},
          '{3'd2, 3'd7, 1'b1}, '{3'd7, 3'd2, 1'b1}, '{3'd4, 3'd5, 1'b0}, '{3'd5, 3'd4, 1'b1}},
        '{'{3'd0, 3'd7, 1'b0}, '{3'd7, 3'd0, 1'b0}, '{3'd3, 3'd4, 1'b0}, '{3'd4, 3'd3, 1'b0},
          '{3'd1, 3'd5, 1'b0}, '{3'd5, 3'd1, 1'b0}, '{3'd2, 3'd6, 1'b1}, '{3'd6, 3'd2, 1'b1}}
    };

    function automatic logic signed [COMP_W-1:0] get_lane(
        input logic [LANES*COMP_W-1:0] word,
        input logic [1:0]              idx
    );
        get_lane = $signed(word[idx*COMP_W +: COMP_W]);
    endfunction

endpackage

// ===== hdl/cl3_gp_accum.sv =====
// Signed sum of one component's eight products, floor shift and saturation.
module cl3_gp_accum (
    input  logic [cl3_gp_pkg::NUM_BLADE-1:0][cl3_gp_pkg::PROD_W-1:0] i_prod,
    input  logic [cl3_gp_pkg::NUM_BLADE-1:0]                         i_neg,
    output logic signed [cl3_gp_pkg::COMP_W-1:0]                     o_value
);
    import cl3_gp_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sd32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-32'sd32768);

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_shift;

    always_comb begin
        logic signed [SUM_W-1:0] term;
        w_sum = '0;
        for (int j = 0; j < NUM_BLADE; j++) begin
            term = SUM_W'($signed(i_prod[j]));
            if (i_neg[j]) begin
                w_sum = w_sum - term;
            end else begin
                w_sum = w_sum + term;
            end
        end
    end

    // arithmetic shift rounds toward minus infinity
    assign w_shift = w_sum >>> FRAC_BITS;

    always_comb begin
        if (w_shift > SAT_MAX) begin
            o_value = SAT_MAX[COMP_W-1:0];
        end else if (w_shift < SAT_MIN) begin
            o_value = SAT_MIN[COMP_W-1:0];
        end else begin
            o_value = w_shift[COMP_W-1:0];
        end
    end

endmodule

// ===== hdl/cl3_geometric_product_unit.sv =====
// Cl(3,0) geometric product of two multivectors in signed Q8.8, one word per
// clock cycle sustained while the output side does not stall. A word is held
// in the input register. In the next cycle all 64 component products are
// formed, and each component's eight products are summed, floored by FRAC_BITS
// and saturated to 16 bits into the result register, which holds the result
// until the output side takes it. Each register refills as soon as it drains,
// so o_in_stall rises only when both registers hold words and the output side
// stalls.
module cl3_geometric_product_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cl3_gp_pkg::t_gp_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cl3_gp_pkg::t_gp_out  o_out_data
);
    import cl3_gp_pkg::*;

    t_gp_in  r_in;
    logic    r_in_valid;
    t_gp_out r_out;
    logic    r_out_valid;

    logic [NUM_BLADE-1:0][NUM_BLADE-1:0][PROD_W-1:0] w_prod;
    logic [NUM_BLADE-1:0][NUM_BLADE-1:0]             w_neg;

    logic signed [COMP_W-1:0] w_a [NUM_BLADE];
    logic signed [COMP_W-1:0] w_b [NUM_BLADE];
    logic signed [COMP_W-1:0] w_res [NUM_BLADE];
    t_gp_out                  n_out;

    logic w_en_out;
    logic w_en_in;

    // each register advances when it is empty or the next one advances
    assign w_en_out  = !r_out_valid || !i_out_stall;
    assign w_en_in   = !r_in_valid || w_en_out;
    assign o_in_stall = !w_en_in;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            w_a[k]         = get_lane(r_in.left_low, 2'(k));
            w_a[k + LANES] = get_lane(r_in.left_high, 2'(k));
            w_b[k]         = get_lane(r_in.right_low, 2'(k));
            w_b[k + LANES] = get_lane(r_in.right_high, 2'(k));
        end
    end

    for (genvar k = 0; k < NUM_BLADE; k++) begin : g_comp
        for (genvar j = 0; j < NUM_BLADE; j++) begin : g_term
            assign w_prod[k][j] = PROD_W'(w_a[GP_TABLE[k][j].left])
                                * PROD_W'(w_b[GP_TABLE[k][j].right]);
            assign w_neg[k][j]  = GP_TABLE[k][j].neg;
        end

        cl3_gp_accum u_accum (
            .i_prod  (w_prod[k]),
            .i_neg   (w_neg[k]),
            .o_value (w_res[k])
        );
    end

    always_comb begin
        n_out.prod_scalar = w_res[0];
        n_out.prod_e1     = w_res[1];
        n_out.prod_e2     = w_res[2];
        n_out.prod_e3     = w_res[3];
        n_out.prod_e12    = w_res[4];
        n_out.prod_e23    = w_res[5];
        n_out.prod_e13    = w_res[6];
        n_out.prod_e123   = w_res[7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_en_in) begin
                r_in_valid <= i_in_valid;
            end
            if (w_en_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_in && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_en_out && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`include "cl3_geometric_product_unit_assert.svh"

    // back-pressure reaches the input only with both registers occupied
    `CL3_GPU_ASSERT_IMP(a_stall_full, o_in_stall, r_in_valid && r_out_valid)
    // an accepted word lands in the input register
    `CL3_GPU_ASSERT_NXT(a_in_lands, i_in_valid && !o_in_stall, r_in_valid)
    // a result appears only from a filled input register
    `CL3_GPU_ASSERT_IMP(a_out_source, $rose(r_out_valid), $past(r_in_valid))
    // a stalled result stays put and unchanged
    `CL3_GPU_ASSERT_NXT(a_out_held, r_out_valid && i_out_stall, r_out_valid && $stable(r_out))

endmodule

// ===== tb/cl3_gp_product_checker.sv =====
module cl3_gp_product_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  cl3_gp_pkg::t_gp_in  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  cl3_gp_pkg::t_gp_out i_out_data,
    output int                  o_errors,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cl3_gp_pkg::*;

    // blade order as on the ports, each as a set of basis vectors: bit 0 e1, bit 1 e2, bit 2 e3
    localparam logic [2:0] BLADE_BITS [8] = '{
        3'b000, 3'b001, 3'b010, 3'b100, 3'b011, 3'b110, 3'b101, 3'b111
    };

    t_gp_out products_due [$];
    int      mismatch_count = 0;
    int      due_count      = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = due_count;

    function automatic int blade_of_bits(input logic [2:0] bits);
        int found;
        found = 0;
        for (int n = 0; n < 8; n++) begin
            if (BLADE_BITS[n] == bits) found = n;
        end
        return found;
    endfunction

    // odd number of transpositions to bring the basis vectors into order: negate
    function automatic bit reorder_is_odd(input logic [2:0] lb, input logic [2:0] rb);
        int swaps;
        swaps = 0;
        for (int r = 0; r < 3; r++) begin
            if (rb[r]) begin
                for (int l = r + 1; l < 3; l++) begin
                    if (lb[l]) swaps++;
                end
            end
        end
        return swaps[0];
    endfunction

    function automatic t_gp_out geometric_product(input t_gp_in w);
        shortint lhs [8];
        shortint rhs [8];
        longint  acc [8];
        shortint comp [8];
        longint  term;
        longint  floored;
        int      k;
        for (int n = 0; n < 4; n++) begin
            lhs[n]     = w.left_low[16*n +: 16];
            lhs[n + 4] = w.left_high[16*n +: 16];
            rhs[n]     = w.right_low[16*n +: 16];
            rhs[n + 4] = w.right_high[16*n +: 16];
        end
        for (int n = 0; n < 8; n++) acc[n] = 0;
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                term = longint'(lhs[i]) * longint'(rhs[j]);
                k    = blade_of_bits(BLADE_BITS[i] ^ BLADE_BITS[j]);
                if (reorder_is_odd(BLADE_BITS[i], BLADE_BITS[j])) acc[k] -= term;
                else acc[k] += term;
            end
        end
        for (int n = 0; n < 8; n++) begin
            // arithmetic shift of a signed value floors toward minus infinity
            floored = acc[n] >>> FRAC_BITS;
            if (floored > 32767) comp[n] = 16'sh7FFF;
            else if (floored < -32768) comp[n] = 16'sh8000;
            else comp[n] = shortint'(floored);
        end
        return {comp[0], comp[1], comp[2], comp[3], comp[4], comp[5], comp[6], comp[7]};
    endfunction

    task automatic compare_product(input t_gp_out want, input t_gp_out got);
        string names [8];
        logic [15:0] w16;
        logic [15:0] g16;
        names = '{"scalar", "e1", "e2", "e3", "e12", "e23", "e13", "e123"};
        for (int k = 0; k < 8; k++) begin
            w16 = want[16*(7-k) +: 16];
            g16 = got[16*(7-k) +: 16];
            if (g16 !== w16) begin
                mismatch_count++;
                $display("%0t ns: prod_%s expected %0d got %0d", $time, names[k],
                         $signed(w16), $signed(g16));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // drain before fill: a word can never leave in the cycle it arrives
            if (i_out_valid && !i_out_stall) begin
                if (products_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result word with none expected, got %h",
                             $time, i_out_data);
                end else begin
                    compare_product(products_due.pop_front(), i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                products_due.push_back(geometric_product(i_in_data));
            end
            due_count = products_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cl3_gp_pkg::*;

    localparam int RANDOM_WORDS = 1350;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_LEN    = 150;

    localparam int STYLE_WIDE  = 0;
    localparam int STYLE_SMALL = 1;
    localparam int STYLE_EDGE  = 2;
    localparam int STYLE_MIXED = 3;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    t_gp_in  in_data   = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    t_gp_out out_data;
    int      errors;
    int      pending;
    int      cycles    = 0;
    bit      send_calm = 1'b0;
    bit      recv_calm = 1'b0;

    always #5 clk = ~clk;

    cl3_geometric_product_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    cl3_gp_product_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[cl3_geometric_product_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_lane(input int style);
        logic [15:0] v;
        case (style)
            STYLE_SMALL: begin
                v = 16'($urandom_range(0, 1023));
                v = v - 16'd512;
            end
            STYLE_EDGE: begin
                case ($urandom_range(0, 6))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    4: v = 16'h0100;
                    5: v = 16'hFF00;
                    default: v = 16'h0001;
                endcase
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_gp_in make_word(input int style);
        logic [255:0] bits;
        int lane_style;
        for (int n = 0; n < 16; n++) begin
            lane_style = (style == STYLE_MIXED) ? $urandom_range(STYLE_WIDE, STYLE_EDGE) : style;
            bits[16*n +: 16] = pick_lane(lane_style);
        end
        return bits;
    endfunction

    function automatic t_gp_in uniform_word(input logic [15:0] lv, input logic [15:0] rv);
        t_gp_in w;
        w.left_low   = {4{lv}};
        w.left_high  = {4{lv}};
        w.right_low  = {4{rv}};
        w.right_high = {4{rv}};
        return w;
    endfunction

    // one non-zero blade on each side
    function automatic t_gp_in blade_word(input int lb, input logic [15:0] lv,
                                          input int rb, input logic [15:0] rv);
        t_gp_in w;
        w = '0;
        if (lb < 4) w.left_low[16*lb +: 16] = lv;
        else w.left_high[16*(lb-4) +: 16] = lv;
        if (rb < 4) w.right_low[16*rb +: 16] = rv;
        else w.right_high[16*(rb-4) +: 16] = rv;
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input t_gp_in w);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    initial begin : drain
        int hold;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = recv_calm ? 0 : $urandom_range(0, 18);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        int pick;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(uniform_word(16'h0000, 16'h0000));
        send_word(uniform_word(16'h7FFF, 16'h7FFF));
        send_word(uniform_word(16'h8000, 16'h8000));
        send_word(uniform_word(16'h7FFF, 16'h8000));
        send_word(uniform_word(16'hFFFF, 16'hFFFF));
        send_word(uniform_word(16'hFFFF, 16'h0001));
        // smallest negative product: floor gives -1, not 0
        send_word(blade_word(0, 16'hFFFF, 0, 16'h0001));
        // saturate high, then low through e12 squared
        send_word(blade_word(0, 16'h7FFF, 0, 16'h7FFF));
        send_word(blade_word(4, 16'h7FFF, 4, 16'h7FFF));
        send_word(blade_word(0, 16'h8000, 0, 16'h8000));
        send_word(blade_word(7, 16'h8000, 7, 16'h7FFF));
        for (int b = 0; b < 8; b++) begin
            send_word(blade_word(b, 16'h0100, (3 * b + 1) % 8, 16'h0100));
        end
        send_word(make_word(STYLE_WIDE));
        send_word(make_word(STYLE_EDGE));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_LEN == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) send_word(make_word(STYLE_WIDE));
            else if (pick < 75) send_word(make_word(STYLE_SMALL));
            else if (pick < 85) send_word(make_word(STYLE_EDGE));
            else send_word(make_word(STYLE_MIXED));
        end
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        // let any stray word surface after the last expected one
        repeat (10) @(negedge clk);
        if (errors == 0) begin
            $display("[cl3_geometric_product_unit] OK");
        end else begin
            $display("[cl3_geometric_product_unit] ERROR");
        end
        $finish;
    end

endmodule
